@@ hw/rtl/apbt_pkg.sv @@
// shared constants and codes for the affine point and box transform
`default_nettype none

package apbt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COEF_XX = 3'd0,
        REG_COEF_XY = 3'd1,
        REG_SHIFT_X = 3'd2,
        REG_COEF_YX = 3'd3,
        REG_COEF_YY = 3'd4,
        REG_SHIFT_Y = 3'd5
    } reg_index_t;

    localparam logic ACT_POINT = 1'b0;
    localparam logic ACT_BOX   = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/affine_point_and_box_transform_top.sv @@
// top level: pipelined 2d affine transform of points and rectangle bounding boxes
// throughput: one beat per cycle while the output is not stalled; eight multipliers, each split in two partial products
// stage ready is local, so empty stages fill while the output is stalled
// reset: all stage valids clear, coefficients return to identity, shifts to zero
`default_nettype none

module affine_point_and_box_transform_top #(
    parameter int COORD_WIDTH = apbt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = apbt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // config write port
    input  wire logic                                   cfg_we,
    input  wire logic [apbt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [COORD_WIDTH-1:0]                 cfg_data,
    // input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // in_x, in_y, in_width, in_height
    input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    // action
    input  wire logic                                   s_tuser,
    // output stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // out_x, out_y, out_width, out_height
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]          m_tdata
);
    import apbt_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int DATA_W  = ((4*W+7)/8)*8;
    localparam int PROD_W  = 2*W;
    localparam int LO_W    = W/2;
    localparam int HI_W    = W - LO_W;
    localparam int PPH_W   = W + HI_W;
    localparam int PPL_W   = W + LO_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int NSTAGE  = 7;

    localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_FX = (F < W) ? ({{(W-1){1'b0}}, 1'b1} << F) : '0;

    // saturate a value one bit wider than a coordinate
    function automatic logic signed [W-1:0] sat_w1(input logic signed [W:0] v);
        logic signed [W-1:0] r;
        if (v[W] != v[W-1])
            r = v[W] ? MIN_V : MAX_V;
        else
            r = v[W-1:0];
        return r;
    endfunction

    // saturate a full sum of two shifted products and a translation
    function automatic logic signed [W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [W-1:0] r;
        if (v[SUM_W-1:W-1] != {(SUM_W-W+1){v[W-1]}})
            r = v[SUM_W-1] ? MIN_V : MAX_V;
        else
            r = v[W-1:0];
        return r;
    endfunction

    // configuration registers
    logic signed [W-1:0] coef_xx_reg, coef_xy_reg, shift_x_reg;
    logic signed [W-1:0] coef_yx_reg, coef_yy_reg, shift_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= ONE_FX;
            coef_xy_reg <= '0;
            shift_x_reg <= '0;
            coef_yx_reg <= '0;
            coef_yy_reg <= ONE_FX;
            shift_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COEF_XX: coef_xx_reg <= cfg_data;
                REG_COEF_XY: coef_xy_reg <= cfg_data;
                REG_SHIFT_X: shift_x_reg <= cfg_data;
                REG_COEF_YX: coef_yx_reg <= cfg_data;
                REG_COEF_YY: coef_yy_reg <= cfg_data;
                REG_SHIFT_Y: shift_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and local ready chain
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE:0]   ready;

    always_comb
    begin
        ready[NSTAGE] = m_tready;
        for (int k = NSTAGE - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (ready[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (ready[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign s_tready = ready[0];

    // stage 1: far edges of the rectangle
    logic signed [W-1:0] in_x, in_y, in_width, in_height;
    logic signed [W:0]   right_sum, bottom_diff;
    logic signed [W-1:0] s1_l_reg, s1_t_reg, s1_r_reg, s1_b_reg;
    logic                s1_act_reg;

    assign in_x      = s_tdata[W-1:0];
    assign in_y      = s_tdata[2*W-1:W];
    assign in_width  = s_tdata[3*W-1:2*W];
    assign in_height = s_tdata[4*W-1:3*W];
    assign right_sum   = (W+1)'(in_x) + (W+1)'(in_width);
    assign bottom_diff = (W+1)'(in_y) - (W+1)'(in_height);

    always_ff @(posedge clk)
    begin
        if (ready[0] && s_tvalid)
        begin
            s1_l_reg   <= in_x;
            s1_t_reg   <= in_y;
            s1_r_reg   <= sat_w1(right_sum);
            s1_b_reg   <= sat_w1(bottom_diff);
            s1_act_reg <= s_tuser;
        end
    end

    // stage 2: partial products, low and high halves of the coordinate
    // product order: xx*l, xx*r, xy*t, xy*b, yx*l, yx*r, yy*t, yy*b
    logic signed [W-1:0]     mul_a [8];
    logic signed [W-1:0]     mul_b [8];
    logic signed [PPH_W-1:0] s2_pph_reg [8];
    logic signed [PPL_W-1:0] s2_ppl_reg [8];
    logic                    s2_act_reg;

    always_comb
    begin
        mul_a[0] = coef_xx_reg;  mul_b[0] = s1_l_reg;
        mul_a[1] = coef_xx_reg;  mul_b[1] = s1_r_reg;
        mul_a[2] = coef_xy_reg;  mul_b[2] = s1_t_reg;
        mul_a[3] = coef_xy_reg;  mul_b[3] = s1_b_reg;
        mul_a[4] = coef_yx_reg;  mul_b[4] = s1_l_reg;
        mul_a[5] = coef_yx_reg;  mul_b[5] = s1_r_reg;
        mul_a[6] = coef_yy_reg;  mul_b[6] = s1_t_reg;
        mul_a[7] = coef_yy_reg;  mul_b[7] = s1_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready[1] && valid_reg[0])
        begin
            for (int k = 0; k < 8; k++)
            begin
                s2_pph_reg[k] <= PPH_W'(mul_a[k]) * PPH_W'($signed(mul_b[k][W-1:LO_W]));
                s2_ppl_reg[k] <= PPL_W'(mul_a[k])
                               * PPL_W'($signed({1'b0, mul_b[k][LO_W-1:0]}));
            end
            s2_act_reg <= s1_act_reg;
        end
    end

    // stage 3: full product, fraction bits dropped toward minus infinity
    logic signed [PROD_W-1:0] full_prod [8];
    logic signed [PROD_W-1:0] s3_prod_reg [8];
    logic                     s3_act_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
            full_prod[k] = $signed({s2_pph_reg[k], {LO_W{1'b0}}}) + PROD_W'(s2_ppl_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (ready[2] && valid_reg[1])
        begin
            for (int k = 0; k < 8; k++)
                s3_prod_reg[k] <= full_prod[k] >>> F;
            s3_act_reg <= s2_act_reg;
        end
    end

    // stage 4: mapped corners, corner order (l,t) (r,t) (r,b) (l,b)
    logic signed [SUM_W-1:0] sum_x [4];
    logic signed [SUM_W-1:0] sum_y [4];
    logic signed [W-1:0]     s4_px_reg [4];
    logic signed [W-1:0]     s4_py_reg [4];
    logic                    s4_act_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_x[c] = SUM_W'(s3_prod_reg[(c == 1 || c == 2) ? 1 : 0])
                     + SUM_W'(s3_prod_reg[(c >= 2) ? 3 : 2])
                     + SUM_W'(shift_x_reg);
            sum_y[c] = SUM_W'(s3_prod_reg[(c == 1 || c == 2) ? 5 : 4])
                     + SUM_W'(s3_prod_reg[(c >= 2) ? 7 : 6])
                     + SUM_W'(shift_y_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[3] && valid_reg[2])
        begin
            for (int c = 0; c < 4; c++)
            begin
                s4_px_reg[c] <= sat_sum(sum_x[c]);
                s4_py_reg[c] <= sat_sum(sum_y[c]);
            end
            s4_act_reg <= s3_act_reg;
        end
    end

    // stage 5: min and max over corner pairs
    logic signed [W-1:0] s5_minx_reg [2];
    logic signed [W-1:0] s5_maxx_reg [2];
    logic signed [W-1:0] s5_miny_reg [2];
    logic signed [W-1:0] s5_maxy_reg [2];
    logic signed [W-1:0] s5_px0_reg, s5_py0_reg;
    logic                s5_act_reg;

    always_ff @(posedge clk)
    begin
        if (ready[4] && valid_reg[3])
        begin
            for (int p = 0; p < 2; p++)
            begin
                if (s4_px_reg[2*p+1] < s4_px_reg[2*p])
                begin
                    s5_minx_reg[p] <= s4_px_reg[2*p+1];
                    s5_maxx_reg[p] <= s4_px_reg[2*p];
                end
                else
                begin
                    s5_minx_reg[p] <= s4_px_reg[2*p];
                    s5_maxx_reg[p] <= s4_px_reg[2*p+1];
                end
                if (s4_py_reg[2*p+1] < s4_py_reg[2*p])
                begin
                    s5_miny_reg[p] <= s4_py_reg[2*p+1];
                    s5_maxy_reg[p] <= s4_py_reg[2*p];
                end
                else
                begin
                    s5_miny_reg[p] <= s4_py_reg[2*p];
                    s5_maxy_reg[p] <= s4_py_reg[2*p+1];
                end
            end
            s5_px0_reg <= s4_px_reg[0];
            s5_py0_reg <= s4_py_reg[0];
            s5_act_reg <= s4_act_reg;
        end
    end

    // stage 6: final min and max
    logic signed [W-1:0] s6_minx_reg, s6_maxx_reg, s6_miny_reg, s6_maxy_reg;
    logic signed [W-1:0] s6_px0_reg, s6_py0_reg;
    logic                s6_act_reg;

    always_ff @(posedge clk)
    begin
        if (ready[5] && valid_reg[4])
        begin
            s6_minx_reg <= (s5_minx_reg[1] < s5_minx_reg[0]) ? s5_minx_reg[1] : s5_minx_reg[0];
            s6_maxx_reg <= (s5_maxx_reg[0] < s5_maxx_reg[1]) ? s5_maxx_reg[1] : s5_maxx_reg[0];
            s6_miny_reg <= (s5_miny_reg[1] < s5_miny_reg[0]) ? s5_miny_reg[1] : s5_miny_reg[0];
            s6_maxy_reg <= (s5_maxy_reg[0] < s5_maxy_reg[1]) ? s5_maxy_reg[1] : s5_maxy_reg[0];
            s6_px0_reg  <= s5_px0_reg;
            s6_py0_reg  <= s5_py0_reg;
            s6_act_reg  <= s5_act_reg;
        end
    end

    // stage 7: box extent and result select, output register
    logic signed [W:0]   ext_x, ext_y;
    logic signed [W-1:0] res_x, res_y, res_w, res_h;
    logic [DATA_W-1:0]   m_tdata_reg;

    assign ext_x = (W+1)'(s6_maxx_reg) - (W+1)'(s6_minx_reg);
    assign ext_y = (W+1)'(s6_maxy_reg) - (W+1)'(s6_miny_reg);

    always_comb
    begin
        if (s6_act_reg == ACT_BOX)
        begin
            res_x = s6_minx_reg;
            res_y = s6_maxy_reg;
            res_w = sat_w1(ext_x);
            res_h = sat_w1(ext_y);
        end
        else
        begin
            res_x = s6_px0_reg;
            res_y = s6_py0_reg;
            res_w = '0;
            res_h = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[6] && valid_reg[5])
            m_tdata_reg <= DATA_W'({res_h, res_w, res_y, res_x});
    end

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/apbt_checker.sv @@
// port-level checks for the affine point and box transform
`default_nettype none

module apbt_checker #(
    parameter int COORD_WIDTH = apbt_pkg::COORD_WIDTH_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    // out_x, out_y, out_width, out_height
    input wire logic [((4*COORD_WIDTH+7)/8)*8-1:0]  m_tdata
);
    import apbt_pkg::*;

    localparam int W = COORD_WIDTH;

    // a stalled output beat holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // box and point extents are never negative, point extents being zero
    a_extent_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[3*W-1] && !m_tdata[4*W-1])
        else $error("negative width or height on output");

    // an open or empty output leaves the whole pipe able to take a beat
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled with a free pipeline");

endmodule

bind affine_point_and_box_transform_top apbt_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_apbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the affine point and box transform top level
`default_nettype none

module testbench;
    import apbt_pkg::*;

    localparam int CW   = COORD_WIDTH_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam int DW   = ((4 * CW + 7) / 8) * 8;

    localparam int COORD_MAX = 32'sh7fff_ffff;
    localparam int COORD_MIN = 32'sh8000_0000;
    localparam int ONE       = 32'sh0001_0000;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_HI = 3'd7;

    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_ITEMS  = 160;
    localparam int HOLD_AFTER     = 1034;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic          action;
        logic [CW-1:0] height;
        logic [CW-1:0] width;
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } geom_item_t;

    // out_x in the low bits, same order as m_tdata
    typedef struct packed {
        logic [CW-1:0] height;
        logic [CW-1:0] width;
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } geom_result_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0]              cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [DW-1:0]              s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [DW-1:0]              m_tdata;

    geom_item_t   pending_shapes [$];
    geom_result_t expected_boxes [$];
    geom_item_t   shape_on_bus;
    geom_item_t   next_shape;
    geom_result_t got_box;
    geom_result_t want_box;

    int xform_reg [6];
    int send_idle_pct = 7;
    int recv_idle_pct = 71;
    int hold_left;
    logic hold_armed;

    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned points_sent     = 0;
    int unsigned boxes_sent      = 0;
    int unsigned settings_used   = 0;

    string field_name [4] = '{"out_x", "out_y", "out_width", "out_height"};

    affine_point_and_box_transform_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d beats still expected", expected_boxes.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic int clamp_coord(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return int'(v);
    endfunction

    // products drop their fraction bits by arithmetic shift, one saturation on the sum
    function automatic int affine_row(input int wa, input int wb, input int shift,
                                      input int px, input int py);
        longint acc;
        acc = ((longint'(wa) * longint'(px)) >>> FRAC)
            + ((longint'(wb) * longint'(py)) >>> FRAC)
            + longint'(shift);
        return clamp_coord(acc);
    endfunction

    function automatic geom_result_t predict_transform(input geom_item_t it);
        geom_result_t r;
        int cx [4];
        int cy [4];
        int left, top, right, bottom;
        int px, py, min_x, max_x, min_y, max_y;
        left = int'(it.x);
        top  = int'(it.y);
        if (it.action == ACT_POINT)
        begin
            r.x      = affine_row(xform_reg[REG_COEF_XX], xform_reg[REG_COEF_XY],
                                  xform_reg[REG_SHIFT_X], left, top);
            r.y      = affine_row(xform_reg[REG_COEF_YX], xform_reg[REG_COEF_YY],
                                  xform_reg[REG_SHIFT_Y], left, top);
            r.width  = '0;
            r.height = '0;
        end
        else
        begin
            // y points up, so the bottom edge is top minus height
            right  = clamp_coord(longint'(left) + longint'(int'(it.width)));
            bottom = clamp_coord(longint'(top) - longint'(int'(it.height)));
            cx[0] = left;  cy[0] = top;
            cx[1] = right; cy[1] = top;
            cx[2] = right; cy[2] = bottom;
            cx[3] = left;  cy[3] = bottom;
            min_x = 0; max_x = 0; min_y = 0; max_y = 0;
            for (int i = 0; i < 4; i++)
            begin
                px = affine_row(xform_reg[REG_COEF_XX], xform_reg[REG_COEF_XY],
                                xform_reg[REG_SHIFT_X], cx[i], cy[i]);
                py = affine_row(xform_reg[REG_COEF_YX], xform_reg[REG_COEF_YY],
                                xform_reg[REG_SHIFT_Y], cx[i], cy[i]);
                if (i == 0 || px < min_x) min_x = px;
                if (i == 0 || px > max_x) max_x = px;
                if (i == 0 || py < min_y) min_y = py;
                if (i == 0 || py > max_y) max_y = py;
            end
            r.x      = min_x;
            r.y      = max_y;
            r.width  = clamp_coord(longint'(max_x) - longint'(min_x));
            r.height = clamp_coord(longint'(max_y) - longint'(min_y));
        end
        return r;
    endfunction

    function automatic int random_coord();
        case ($urandom_range(9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return int'($urandom_range(0, 8)) - 4;
            3, 4, 5: return int'($urandom());
            default: return int'($urandom_range(0, 2 ** 26)) - 2 ** 25;
        endcase
    endfunction

    function automatic int random_weight();
        return int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
    endfunction

    // stream driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_boxes.push_back(predict_transform(shape_on_bus));
                if (shape_on_bus.action == ACT_BOX)
                    boxes_sent++;
                else
                    points_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_shapes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_shape = pending_shapes.pop_front();
                    shape_on_bus <= next_shape;
                    s_tdata      <= {next_shape.height, next_shape.width,
                                     next_shape.y, next_shape.x};
                    s_tuser      <= next_shape.action;
                    s_tvalid     <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with one long hold-off so the pipeline backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && results_checked >= HOLD_AFTER)
        begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_box = m_tdata;
            results_checked++;
            if (expected_boxes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, got %h",
                         $time, m_tdata);
            end
            else
            begin
                want_box = expected_boxes.pop_front();
                for (int f = 0; f < 4; f++)
                begin
                    if (got_box[f*CW +: CW] !== want_box[f*CW +: CW])
                    begin
                        mismatch_count++;
                        $display("%0t: %s expected %0d, got %0d", $time, field_name[f],
                                 $signed(want_box[f*CW +: CW]),
                                 $signed(got_box[f*CW +: CW]));
                    end
                end
            end
        end
    end

    task automatic push_item(input logic action, input int x, input int y,
                             input int w, input int h);
        geom_item_t it;
        it.action = action;
        it.x      = x;
        it.y      = y;
        it.width  = w;
        it.height = h;
        pending_shapes.push_back(it);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_shapes.size() != 0 || s_tvalid || expected_boxes.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx <= REG_SHIFT_Y)
            xform_reg[idx] = val;
    endtask

    task automatic load_transform(input int xx, input int xy, input int sx,
                                  input int yx, input int yy, input int sy);
        write_reg(REG_COEF_XX, xx);
        write_reg(REG_COEF_XY, xy);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_COEF_YX, yx);
        write_reg(REG_COEF_YY, yy);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(IDX_SPARE_LO, int'($urandom()));
        write_reg(IDX_SPARE_HI, int'($urandom()));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin
        int pick;
        int left, top;
        xform_reg[REG_COEF_XX] = ONE;
        xform_reg[REG_COEF_XY] = 0;
        xform_reg[REG_SHIFT_X] = 0;
        xform_reg[REG_COEF_YX] = 0;
        xform_reg[REG_COEF_YY] = ONE;
        xform_reg[REG_SHIFT_Y] = 0;
        settings_used = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity after reset: extremes, degenerate and inverted boxes, clamped edges
        push_item(ACT_POINT, 0, 0, 0, 0);
        push_item(ACT_POINT, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        push_item(ACT_POINT, COORD_MIN, COORD_MAX, -ONE, ONE);
        push_item(ACT_POINT, ONE, -ONE, 12345, -777);
        push_item(ACT_POINT, -1, 1, 0, 0);
        push_item(ACT_BOX, 0, 0, 0, 0);
        push_item(ACT_BOX, 2 * ONE, 3 * ONE, 5 * ONE, 4 * ONE);
        push_item(ACT_BOX, 0, 0, -3 * ONE, ONE);
        push_item(ACT_BOX, 0, 0, ONE, -2 * ONE);
        push_item(ACT_BOX, COORD_MAX - 5, 0, COORD_MAX, ONE);
        push_item(ACT_BOX, 0, COORD_MIN, ONE, COORD_MAX);
        push_item(ACT_BOX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN);
        wait_idle();

        // extreme weights and shifts drive sums and extents into saturation
        load_transform(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        push_item(ACT_POINT, ONE, ONE, 0, 0);
        push_item(ACT_POINT, -ONE, -ONE, 0, 0);
        push_item(ACT_POINT, COORD_MAX, COORD_MAX, 0, 0);
        push_item(ACT_POINT, COORD_MIN, COORD_MIN, 0, 0);
        push_item(ACT_POINT, -1, -1, 0, 0);
        push_item(ACT_POINT, 0, 0, COORD_MIN, COORD_MAX);
        push_item(ACT_BOX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        push_item(ACT_BOX, 0, 0, ONE, ONE);
        push_item(ACT_BOX, -ONE, ONE, 2 * ONE, 2 * ONE);
        push_item(ACT_BOX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
        push_item(ACT_BOX, 1, -1, -1, 1);
        push_item(ACT_BOX, 0, 0, COORD_MAX, COORD_MAX);
        wait_idle();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                2: load_transform(int'($urandom()), int'($urandom()), int'($urandom()),
                                  int'($urandom()), int'($urandom()), int'($urandom()));
                4: load_transform(COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MAX, COORD_MAX, COORD_MAX);
                5: load_transform(0, 0, random_coord(), 0, 0, random_coord());
                7: load_transform(COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MIN, COORD_MIN, COORD_MIN);
                default: load_transform(random_weight(), random_weight(),
                                        int'($urandom_range(0, 2 ** 25)) - 2 ** 24,
                                        random_weight(), random_weight(),
                                        int'($urandom_range(0, 2 ** 25)) - 2 ** 24);
            endcase
            if (seg < 3)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 71;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    push_item(ACT_POINT, random_coord(), random_coord(),
                              random_coord(), random_coord());
                end
                else if (pick < 85)
                begin
                    // well-formed box: moderate corner, non-negative size
                    left = int'($urandom_range(0, 2 ** 27)) - 2 ** 26;
                    top  = int'($urandom_range(0, 2 ** 27)) - 2 ** 26;
                    push_item(ACT_BOX, left, top, int'($urandom_range(0, 2 ** 24)),
                              int'($urandom_range(0, 2 ** 24)));
                end
                else
                begin
                    push_item(ACT_BOX, random_coord(), random_coord(),
                              random_coord(), random_coord());
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d points and %0d boxes under %0d transform settings,",
                 points_sent, boxes_sent, settings_used);
        $display("with sender and receiver stalls and one long output hold-off; %0d beats checked",
                 results_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/apbt_pkg.sv
hw/rtl/affine_point_and_box_transform_top.sv
hw/rtl/apbt_checker.sv
tb/testbench.sv
